FILE: src/activation_function_unit_macros.svh
// Assertion macros shared by the activation function unit modules.
`ifndef ACTIVATION_FUNCTION_UNIT_MACROS_SVH
`define ACTIVATION_FUNCTION_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define AFU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define AFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/afu_pkg.sv
// Shared types, constants and knot-table builders for the activation function unit.
package afu_pkg;

  localparam int DATA_W          = 16;
  localparam int LANES_DEF       = 4;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int OUT_DEPTH       = 8;   // result queue entries
  localparam int LANE_LAT        = 5;   // register stages in one lane
  localparam int APB_AW          = 3;
  localparam int APB_DW          = 32;

  localparam logic [APB_AW-1:0] REG_ACTIVATION_KIND = 3'd0;

  localparam logic [1:0] KIND_TANH    = 2'd0;
  localparam logic [1:0] KIND_RELU    = 2'd1;
  localparam logic [1:0] KIND_SIGMOID = 2'd2;

  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] EXP_M1_Q30 = 64'd395007542;

  typedef struct packed {
    logic       func;
    logic [1:0] kind;
  } afu_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } afu_push_t;

  // Shift-subtract divide, used only when the knot tables are elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-x in Q30: Taylor series of the fraction, then e^-1 per whole unit.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] xq);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic        done;
    n    = xq >> 30;
    f    = xq & (ONE_Q30 - 64'd1);
    sum  = ONE_Q30;
    term = ONE_Q30;
    done = 1'b0;
    for (int k = 1; k < 40; k++) begin
      if (!done) begin
        term = udiv64(term * f, 64'(k) << 30);
        if (term == 64'd0) begin
          done = 1'b1;
        end else if ((k & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    v = sum;
    if (n > 64'd64) begin
      return 64'd0;
    end
    for (int k = 0; k < 64; k++) begin
      if (64'(k) < n) begin
        v = (v * EXP_M1_Q30 + (ONE_Q30 >> 1)) >> 30;
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] knot_xq(input int k, input int frac_bits, input int depth);
    return udiv64(64'(k) << (45 - frac_bits), 64'(depth));
  endfunction

  function automatic logic [31:0] sig_knot(input int k, input int frac_bits, input int depth);
    logic [63:0] e;
    logic [63:0] d;
    e = exp_neg_q30(knot_xq(k, frac_bits, depth));
    d = ONE_Q30 + e;
    return 32'(udiv64((64'd1 << 60) + (d >> 1), d));
  endfunction

  function automatic logic [31:0] tanh_knot(input int k, input int frac_bits, input int depth);
    logic [63:0] e2;
    logic [63:0] d2;
    e2 = exp_neg_q30(knot_xq(k, frac_bits, depth) << 1);
    d2 = ONE_Q30 + e2;
    return 32'(udiv64(((ONE_Q30 - e2) << 30) + (d2 >> 1), d2));
  endfunction

endpackage

FILE: src/afu_lane.sv
// One lane: table lookup with interpolation, derivative and Q30 rounding.
module afu_lane #(
  parameter int FRAC_BITS   = afu_pkg::FRAC_BITS_DEF,
  parameter int TABLE_DEPTH = afu_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic signed [afu_pkg::DATA_W-1:0]   x,
  input  afu_pkg::afu_ctl_t                   ctl,
  output logic signed [afu_pkg::DATA_W-1:0]   y
);
  import afu_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH + 1);
  localparam int MAG_W = DATA_W + 1;
  localparam int P_W   = MAG_W + IDX_W;
  localparam int RSH   = 30 - FRAC_BITS;
  localparam logic [31:0] HALF = 32'd1 << (RSH - 1);
  localparam logic [DATA_W-1:0] RELU_ONE =
    (FRAC_BITS >= DATA_W - 1) ? DATA_W'(32767) : DATA_W'(1 << FRAC_BITS);
  localparam logic [31:0] ONE32 = 32'(ONE_Q30);

  logic [31:0] sig_rom  [TABLE_DEPTH+1];
  logic [31:0] tanh_rom [TABLE_DEPTH+1];

  for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_knot
    localparam logic [31:0] SIG_K  = sig_knot(g, FRAC_BITS, TABLE_DEPTH);
    localparam logic [31:0] TANH_K = tanh_knot(g, FRAC_BITS, TABLE_DEPTH);
    assign sig_rom[g]  = SIG_K;
    assign tanh_rom[g] = TANH_K;
  end

  // Stage 0: magnitude, segment and fraction
  logic             neg0;
  logic [MAG_W-1:0] mag0;
  logic [P_W-1:0]   p0;
  logic [IDX_W-1:0] idx_a;
  logic [IDX_W-1:0] idx_b;
  logic             pos0;
  logic [DATA_W-1:0] relu0;

  always_comb begin
    neg0  = x[DATA_W-1];
    mag0  = neg0 ? (MAG_W'(0) - {x[DATA_W-1], x}) : {1'b0, x};
    p0    = P_W'(mag0) * P_W'(TABLE_DEPTH);
    idx_a = p0[15 +: IDX_W];
    idx_b = (idx_a == IDX_W'(TABLE_DEPTH)) ? idx_a : idx_a + 1'b1;
    pos0  = !x[DATA_W-1] && (x != '0);
    if (ctl.func) begin
      relu0 = pos0 ? RELU_ONE : '0;
    end else begin
      relu0 = pos0 ? x : '0;
    end
  end

  logic [31:0]       knot_a;
  logic [31:0]       knot_b;
  logic [14:0]       frac1;
  logic              neg1;
  afu_ctl_t          ctl1;
  logic [DATA_W-1:0] relu1;

  always_ff @(posedge clk) begin
    knot_a <= (ctl.kind == KIND_TANH) ? tanh_rom[idx_a] : sig_rom[idx_a];
    knot_b <= (ctl.kind == KIND_TANH) ? tanh_rom[idx_b] : sig_rom[idx_b];
    frac1  <= p0[14:0];
    neg1   <= neg0;
    ctl1   <= ctl;
    relu1  <= relu0;
  end

  // Stage 1: slope times fraction
  logic [32:0] diff1;
  logic        dneg1;
  logic [31:0] dmag1;

  always_comb begin
    diff1 = {1'b0, knot_b} - {1'b0, knot_a};
    dneg1 = diff1[32];
    dmag1 = dneg1 ? 32'(33'd0 - diff1) : diff1[31:0];
  end

  logic [46:0]       prod1;
  logic [31:0]       a2;
  logic              dneg2;
  logic              neg2;
  afu_ctl_t          ctl2;
  logic [DATA_W-1:0] relu2;

  always_ff @(posedge clk) begin
    prod1 <= 47'(dmag1) * 47'(frac1);
    a2    <= knot_a;
    dneg2 <= dneg1;
    neg2  <= neg1;
    ctl2  <= ctl1;
    relu2 <= relu1;
  end

  // Stage 2: interpolated value, symmetry, multiplier operands
  logic [31:0]        step2;
  logic [31:0]        t2;
  logic [31:0]        sv2;
  logic signed [31:0] val2;
  logic [30:0]        op1_2;
  logic [30:0]        op2_2;

  always_comb begin
    step2 = 32'((prod1 + 47'd16384) >> 15);
    t2    = dneg2 ? a2 - step2 : a2 + step2;
    sv2   = neg2 ? ONE32 - t2 : t2;
    if (ctl2.kind == KIND_TANH) begin
      val2  = neg2 ? $signed(32'd0 - t2) : $signed(t2);
      op1_2 = t2[30:0];
      op2_2 = t2[30:0];
    end else begin
      val2  = $signed(sv2);
      op1_2 = sv2[30:0];
      op2_2 = 31'(ONE32 - sv2);
    end
  end

  logic signed [31:0] val3;
  logic [30:0]        op1_3;
  logic [30:0]        op2_3;
  afu_ctl_t           ctl3;
  logic [DATA_W-1:0]  relu3;

  always_ff @(posedge clk) begin
    val3  <= val2;
    op1_3 <= op1_2;
    op2_3 <= op2_2;
    ctl3  <= ctl2;
    relu3 <= relu2;
  end

  // Stage 3: derivative product
  logic [61:0]        prod4;
  logic signed [31:0] val4;
  afu_ctl_t           ctl4;
  logic [DATA_W-1:0]  relu4;

  always_ff @(posedge clk) begin
    prod4 <= 62'(op1_3) * 62'(op2_3);
    val4  <= val3;
    ctl4  <= ctl3;
    relu4 <= relu3;
  end

  // Stage 4: pick, round Q30 to FRAC_BITS half away from zero, saturate
  logic [31:0]       dq4;
  logic [31:0]       q30;
  logic              qneg;
  logic [31:0]       qmag;
  logic [31:0]       r4;
  logic [DATA_W-1:0] y_next;

  always_comb begin
    dq4 = 32'((prod4 + 62'(ONE_Q30 >> 1)) >> 30);
    if (ctl4.func) begin
      q30 = (ctl4.kind == KIND_TANH) ? ONE32 - dq4 : dq4;
    end else begin
      q30 = val4;
    end
    qneg = q30[31];
    qmag = qneg ? 32'd0 - q30 : q30;
    r4   = (qmag + HALF) >> RSH;
    if (ctl4.kind == KIND_RELU) begin
      y_next = relu4;
    end else if (qneg) begin
      y_next = (r4 > 32'd32768) ? DATA_W'(16'h8000) : DATA_W'(32'd0 - r4);
    end else begin
      y_next = (r4 > 32'd32767) ? DATA_W'(16'h7fff) : r4[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    y <= y_next;
  end

endmodule

FILE: src/afu_merge.sv
// Merges lane results and the frame mark into one queued output transaction.
`include "activation_function_unit_macros.svh"

module afu_merge #(
  parameter int LANES = afu_pkg::LANES_DEF,
  parameter int DEPTH = afu_pkg::OUT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  afu_pkg::afu_push_t                push,
  input  logic [LANES*afu_pkg::DATA_W-1:0]  y_all,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [LANES*afu_pkg::DATA_W-1:0]  m_tdata,
  output logic                              m_tlast
);
  import afu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int ENT_W = LANES * DATA_W + 1;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic [PTR_W:0]   fill_next;
  logic             pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fill != '0);
  assign m_tdata  = mem[rd_ptr][LANES*DATA_W-1:0];
  assign m_tlast  = mem[rd_ptr][ENT_W-1];

  always_comb begin
    fill_next = fill;
    case ({push.valid, pop})
      2'b10:   fill_next = fill + 1'b1;
      2'b01:   fill_next = fill - 1'b1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= {push.last, y_all};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

  `AFU_ASSERT_NOW(a_no_overflow, push.valid, fill < (PTR_W+1)'(DEPTH), "result queue overflow")
  `AFU_ASSERT_NEXT(a_fill_up, push.valid && !pop, fill == $past(fill) + 1'b1, "fill did not rise")
  `AFU_ASSERT_NEXT(a_fill_down, pop && !push.valid, fill == $past(fill) - 1'b1, "fill did not fall")

endmodule

FILE: src/activation_function_unit.sv
// Top level of the activation function unit: APB register, lanes, result queue.
// Usage:
//   Input stream: s_tdata carries LANES signed Q4.12 elements (lane 0 lowest),
//   s_tuser selects the function value (0) or the derivative diagonal (1),
//   s_tlast marks the transaction holding a vector's final elements.
//   Output stream: m_tdata carries one saturated result per lane, m_tlast
//   is the copy of s_tlast. One output transaction per input transaction.
//   activation_kind (APB offset 0): 0 tanh, 1 relu, 2 or 3 sigmoid; write it
//   only while no transaction is in flight.
// Path: m_tvalid rises once a result has passed the five lane stages (the
//   table read clocked at the accepting edge, slope multiply, interpolation,
//   derivative multiply, rounding) and has been written into the result queue.
// Throughput: one transaction per cycle while s_tready is high (pipelined lanes).
// Reset: activation_kind returns to sigmoid, the pipeline and queue empty.
// Stall: the lanes never stop; an 8-entry result queue absorbs results while
//   m_tready is low. s_tready falls once 8 transactions are outstanding and
//   rises again as results are taken, so nothing is lost.
`include "activation_function_unit_macros.svh"

module activation_function_unit #(
  parameter int LANES       = afu_pkg::LANES_DEF,
  parameter int FRAC_BITS   = afu_pkg::FRAC_BITS_DEF,
  parameter int TABLE_DEPTH = afu_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [afu_pkg::APB_AW-1:0]        paddr,
  input  logic [afu_pkg::APB_DW-1:0]        pwdata,
  output logic [afu_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [LANES*afu_pkg::DATA_W-1:0]  s_tdata,  // x_0, x_1, ... x_(LANES-1)
  input  logic                              s_tuser,  // func
  input  logic                              s_tlast,  // last_in
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [LANES*afu_pkg::DATA_W-1:0]  m_tdata,  // y_0, y_1, ... y_(LANES-1)
  output logic                              m_tlast   // last_out
);
  import afu_pkg::*;

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  // ---- configuration register ----
  logic [1:0] kind;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  ({paddr[APB_AW-1:2], 2'b00} == REG_ACTIVATION_KIND);

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_SIGMOID;
    end else if (cfg_wr) begin
      kind <= pwdata[1:0];
    end
  end

  always_comb begin
    if ({paddr[APB_AW-1:2], 2'b00} == REG_ACTIVATION_KIND) begin
      prdata = {{(APB_DW-2){1'b0}}, kind};
    end else begin
      prdata = '0;
    end
  end

  // ---- credit count: transactions accepted but not yet delivered ----
  logic             s_acc;
  logic             m_acc;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign s_tready = (count < CNT_W'(OUT_DEPTH));
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;

  always_comb begin
    case ({s_acc, m_acc})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // ---- lanes; valid and tlast travel beside them ----
  afu_ctl_t                  ctl;
  logic [LANES*DATA_W-1:0]   y_all;
  logic [LANE_LAT-1:0]       vld;
  logic [LANE_LAT-1:0]       last_pipe;
  afu_push_t                 push;

  assign ctl.func = s_tuser;
  assign ctl.kind = kind;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    afu_lane #(
      .FRAC_BITS   (FRAC_BITS),
      .TABLE_DEPTH (TABLE_DEPTH)
    ) u_lane (
      .clk (clk),
      .x   (s_tdata[i*DATA_W +: DATA_W]),
      .ctl (ctl),
      .y   (y_all[i*DATA_W +: DATA_W])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LANE_LAT-2:0], s_acc};
    end
  end

  always_ff @(posedge clk) begin
    last_pipe <= {last_pipe[LANE_LAT-2:0], s_tlast};
  end

  assign push.valid = vld[LANE_LAT-1];
  assign push.last  = last_pipe[LANE_LAT-1];

  // ---- merge lane results into the output queue ----
  afu_merge #(
    .LANES (LANES),
    .DEPTH (OUT_DEPTH)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .y_all    (y_all),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `AFU_ASSERT_NOW(a_cnt_bound, 1'b1, count <= CNT_W'(OUT_DEPTH), "credit count overflow")
  `AFU_ASSERT_NOW(a_out_counted, m_tvalid, count != '0, "output without outstanding transaction")
  `AFU_ASSERT_NEXT(a_cnt_up, s_acc && !m_acc, count == $past(count) + 1'b1, "credit not taken")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for activation_function_unit: stream stimulus and lane result checks.
`timescale 1ns / 100ps

module tb_top;

  localparam int NLANES   = afu_pkg::LANES_DEF;
  localparam int FRAC     = afu_pkg::FRAC_BITS_DEF;
  localparam int KNOTS    = afu_pkg::TABLE_DEPTH_DEF;
  localparam int DW       = NLANES * afu_pkg::DATA_W;
  // pipeline latency plus queue landing, with a little margin
  localparam int SETTLE   = afu_pkg::LANE_LAT + 4;
  localparam int HOLD_CYC = 80;

  localparam logic FUNC_VALUE = 1'b0;
  localparam logic FUNC_DERIV = 1'b1;
  // encoding 3 has no name in the package; the block treats it as sigmoid
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam longint UNIT_Q30  = longint'(1) << 30;
  localparam longint EINV_Q30  = 395007542;  // e^-1 in Q30

  // ---------------------------------------------------------------------------
  // Lane result predictor and store of expected output transactions
  // ---------------------------------------------------------------------------
  class activation_predictor;
    typedef struct packed {
      logic [DW-1:0] y;
      logic          last;
    } lane_result_t;

    logic [1:0]   kind;
    longint       sig_knots[KNOTS+1];
    longint       tanh_knots[KNOTS+1];
    lane_result_t expected_lanes[$];
    int           mismatches;

    function new();
      longint k;
      longint xq;
      longint e;
      longint d;
      kind       = afu_pkg::KIND_SIGMOID;
      mismatches = 0;
      for (k = 0; k <= KNOTS; k++) begin
        xq = (k << (45 - FRAC)) / KNOTS;
        e  = decay_q30(xq);
        d  = UNIT_Q30 + e;
        sig_knots[k] = ((longint'(1) << 60) + d / 2) / d;
        e  = decay_q30(xq * 2);
        d  = UNIT_Q30 + e;
        tanh_knots[k] = (((UNIT_Q30 - e) << 30) + d / 2) / d;
      end
    endfunction

    // e^-x in Q30: series on the fraction, then one e^-1 step per whole unit
    function longint decay_q30(longint xq);
      longint whole;
      longint part;
      longint term;
      longint acc;
      longint k;
      whole = xq >>> 30;
      part  = xq & (UNIT_Q30 - 1);
      acc   = UNIT_Q30;
      term  = UNIT_Q30;
      for (k = 1; k < 40; k++) begin
        term = (term * part) / (k << 30);
        if (term == 0) break;
        if ((k % 2) == 1) acc -= term;
        else acc += term;
      end
      if (whole > 64) return 0;
      for (k = 0; k < whole; k++) acc = (acc * EINV_Q30 + UNIT_Q30 / 2) >>> 30;
      return acc;
    endfunction

    function longint interp(bit use_tanh, longint mag);
      longint p;
      longint seg;
      longint frac;
      longint a;
      longint diff;
      p    = mag * KNOTS;
      seg  = p >>> 15;
      frac = p & 32767;
      if (seg >= KNOTS) return use_tanh ? tanh_knots[KNOTS] : sig_knots[KNOTS];
      a    = use_tanh ? tanh_knots[seg] : sig_knots[seg];
      diff = (use_tanh ? tanh_knots[seg+1] : sig_knots[seg+1]) - a;
      if (diff >= 0) return a + ((diff * frac + 16384) >>> 15);
      return a - (((-diff) * frac + 16384) >>> 15);
    endfunction

    // Q30 to output format, half away from zero
    function longint to_frac(longint v);
      longint half;
      half = longint'(1) << (29 - FRAC);
      if (v >= 0) return (v + half) >>> (30 - FRAC);
      return -(((-v) + half) >>> (30 - FRAC));
    endfunction

    function longint lane_value(logic signed [15:0] xin, logic fn);
      longint x;
      longint mag;
      longint t;
      longint sv;
      bit     neg;
      x   = xin;
      neg = x < 0;
      mag = neg ? -x : x;
      if (kind == afu_pkg::KIND_TANH) begin
        t = interp(1'b1, mag);
        if (fn == FUNC_VALUE) return to_frac(neg ? -t : t);
        return to_frac(UNIT_Q30 - ((t * t + UNIT_Q30 / 2) >>> 30));
      end else if (kind == afu_pkg::KIND_RELU) begin
        if (fn == FUNC_VALUE) return (x > 0) ? x : 0;
        return (x > 0) ? (longint'(1) << FRAC) : 0;
      end
      // sigmoid and the spare encoding
      t  = interp(1'b0, mag);
      sv = neg ? UNIT_Q30 - t : t;
      if (fn == FUNC_VALUE) return to_frac(sv);
      return to_frac((sv * (UNIT_Q30 - sv) + UNIT_Q30 / 2) >>> 30);
    endfunction

    function void predict_item(logic fn, logic [DW-1:0] xs, logic lst);
      lane_result_t r;
      longint       v;
      for (int i = 0; i < NLANES; i++) begin
        v = lane_value($signed(xs[16*i +: 16]), fn);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.y[16*i +: 16] = v[15:0];
      end
      r.last = lst;
      expected_lanes.push_back(r);
    endfunction

    function void compare_result(logic [DW-1:0] ys, logic lst);
      lane_result_t r;
      if (expected_lanes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result y=%h last=%b", ys, lst);
        return;
      end
      r = expected_lanes.pop_front();
      for (int i = 0; i < NLANES; i++) begin
        if (ys[16*i +: 16] !== r.y[16*i +: 16]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: lane %0d expected %h got %h", i, r.y[16*i +: 16], ys[16*i +: 16]);
        end
      end
      if (lst !== r.last) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: last expected %b got %b", r.last, lst);
      end
    endfunction

    function int pending();
      return expected_lanes.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and its inputs; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      psel     = 1'b0;
  logic                      penable  = 1'b0;
  logic                      pwrite   = 1'b0;
  logic [afu_pkg::APB_AW-1:0] paddr   = '0;
  logic [afu_pkg::APB_DW-1:0] pwdata  = '0;
  logic [afu_pkg::APB_DW-1:0] prdata;
  logic                      pready;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [DW-1:0]             s_tdata  = '0;  // x_0, x_1, x_2, x_3
  logic                      s_tuser  = 1'b0; // func
  logic                      s_tlast  = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [DW-1:0]             m_tdata;        // y_0, y_1, y_2, y_3
  logic                      m_tlast;

  activation_function_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  activation_predictor board = new();

  int tx_idle_pct  = 21;
  int rx_idle_pct  = 51;
  bit hold_request = 1'b0;
  int items_sent   = 0;
  int results_seen = 0;
  int writes_done  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output monitor: a transaction completes on tvalid && tready at the edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.compare_result(m_tdata, m_tlast);
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks; each starts and ends just after a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic fn, input logic [DW-1:0] xs, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= xs;
    s_tuser  <= fn;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    board.predict_item(fn, xs, lst);
    items_sent++;
  endtask

  // Block is idle once every expected result is back and the pipe has flushed.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_kind(input logic [1:0] k);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= afu_pkg::REG_ACTIVATION_KIND;
    pwdata  <= {{(afu_pkg::APB_DW-2){1'b0}}, k};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.kind = k;
    writes_done++;
  endtask

  // Element mix: extremes, near zero, knot edges (multiples of 128 +/- 1), full range.
  function automatic logic [15:0] rand_elem();
    logic [15:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          3: v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
      end
      1, 2: v = 16'($urandom_range(2047));
      3: v = 16'(($urandom_range(255) << 7) + $urandom_range(2)) - 16'd1;
      default: v = 16'($urandom);
    endcase
    if ($urandom_range(1) == 1 && v != 16'h8000) v = -v;
    return v;
  endfunction

  task automatic send_random(input int count);
    logic [DW-1:0] xs;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < NLANES; i++) xs[16*i +: 16] = rand_elem();
      send_item(logic'($urandom_range(1)), xs, $urandom_range(3) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0]    kind_cycle[4];
    logic [DW-1:0] edge_vec;
    logic [DW-1:0] mid_vec;
    kind_cycle[0] = afu_pkg::KIND_TANH;
    kind_cycle[1] = afu_pkg::KIND_RELU;
    kind_cycle[2] = afu_pkg::KIND_SIGMOID;
    kind_cycle[3] = KIND_SPARE;
    // lanes from lowest: most negative, most positive, zero, -1
    edge_vec = {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000};
    // lanes from lowest: 1 LSB, -1.0, +1.0, first knot step
    mid_vec  = {16'h0080, 16'h1000, 16'hF000, 16'h0001};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: both functions for each kind, starting from the reset default
    // (sigmoid) without a write; the spare encoding must behave as sigmoid.
    for (int j = 0; j < 4; j++) begin
      if (j > 0) begin
        drain();
        write_kind(kind_cycle[(j + 2) % 4]);
      end
      send_item(FUNC_VALUE, edge_vec, 1'b0);
      send_item(FUNC_DERIV, edge_vec, 1'b1);
      send_item(FUNC_VALUE, mid_vec, 1'b1);
      send_item(FUNC_DERIV, mid_vec, 1'b0);
    end

    // Random: three idling profiles, every kind within each, rotated so each
    // profile starts and ends on a different setting.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin tx_idle_pct = 21; rx_idle_pct = 51; end
        1: begin tx_idle_pct = 51; rx_idle_pct = 21; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int j = 0; j < 4; j++) begin
        drain();
        write_kind(kind_cycle[(j + p) % 4]);
        send_random(150);
        if (p == 0 && j == 1) begin
          // long receiver stall: queue fills and s_tready must drop
          hold_request = 1'b1;
          send_random(40);
        end
      end
    end

    drain();
    $display("Ran %0d input transactions, %0d results, %0d kind writes",
             items_sent, results_seen, writes_done);
    $display("Covered tanh/relu/sigmoid/spare kinds, value and derivative, long stall");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches, board.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
